/* design/fsa_pkg.sv */
package fsa_pkg;

    localparam logic [5:0] ACT_LIT    = 6'd0;
    localparam logic [5:0] ACT_DROP   = 6'd1;
    localparam logic [5:0] ACT_DUP    = 6'd2;
    localparam logic [5:0] ACT_SWAP   = 6'd3;
    localparam logic [5:0] ACT_OVER   = 6'd4;
    localparam logic [5:0] ACT_ROT    = 6'd5;
    localparam logic [5:0] ACT_NIP    = 6'd6;
    localparam logic [5:0] ACT_TUCK   = 6'd7;
    localparam logic [5:0] ACT_2DUP   = 6'd8;
    localparam logic [5:0] ACT_2DROP  = 6'd9;
    localparam logic [5:0] ACT_2SWAP  = 6'd10;
    localparam logic [5:0] ACT_TOR    = 6'd11;
    localparam logic [5:0] ACT_RFROM  = 6'd12;
    localparam logic [5:0] ACT_RFETCH = 6'd13;
    localparam logic [5:0] ACT_ADD    = 6'd14;
    localparam logic [5:0] ACT_SUB    = 6'd15;
    localparam logic [5:0] ACT_MUL    = 6'd16;
    localparam logic [5:0] ACT_DIV    = 6'd17;
    localparam logic [5:0] ACT_MOD    = 6'd18;
    localparam logic [5:0] ACT_ABS    = 6'd19;
    localparam logic [5:0] ACT_NEGATE = 6'd20;
    localparam logic [5:0] ACT_INC    = 6'd21;
    localparam logic [5:0] ACT_DEC    = 6'd22;
    localparam logic [5:0] ACT_AND    = 6'd23;
    localparam logic [5:0] ACT_OR     = 6'd24;
    localparam logic [5:0] ACT_XOR    = 6'd25;
    localparam logic [5:0] ACT_INVERT = 6'd26;
    localparam logic [5:0] ACT_LSHIFT = 6'd27;
    localparam logic [5:0] ACT_RSHIFT = 6'd28;
    localparam logic [5:0] ACT_LT     = 6'd29;
    localparam logic [5:0] ACT_GT     = 6'd30;
    localparam logic [5:0] ACT_EQ     = 6'd31;
    localparam logic [5:0] ACT_NE     = 6'd32;
    localparam logic [5:0] ACT_LE     = 6'd33;
    localparam logic [5:0] ACT_GE     = 6'd34;
    localparam logic [5:0] ACT_ZEQ    = 6'd35;
    localparam logic [5:0] ACT_ZLT    = 6'd36;
    localparam logic [5:0] ACT_ZGT    = 6'd37;

    localparam logic [2:0] ERR_OK      = 3'd0;
    localparam logic [2:0] ERR_D_UNDER = 3'd1;
    localparam logic [2:0] ERR_D_OVER  = 3'd2;
    localparam logic [2:0] ERR_R_UNDER = 3'd3;
    localparam logic [2:0] ERR_R_OVER  = 3'd4;
    localparam logic [2:0] ERR_DIV0    = 3'd5;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [5:0]  action;
        logic [63:0] literal;
        logic [2:0]  pops;
        logic [2:0]  pushes;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_READ, ST_EVAL, ST_MUL, ST_DIV, ST_WRITE, ST_DONE
    } t_state;

    function automatic logic [2:0] pop_count(input logic [5:0] act);
        logic [2:0] n;
        case (act)
            ACT_LIT, ACT_RFROM, ACT_RFETCH:                      n = 3'd0;
            ACT_DROP, ACT_DUP, ACT_TOR, ACT_ABS, ACT_NEGATE,
            ACT_INC, ACT_DEC, ACT_INVERT, ACT_ZEQ, ACT_ZLT,
            ACT_ZGT:                                             n = 3'd1;
            ACT_ROT:                                             n = 3'd3;
            ACT_2SWAP:                                           n = 3'd4;
            default:                                             n = (act > ACT_ZGT) ? 3'd0 : 3'd2;
        endcase
        return n;
    endfunction

    function automatic logic [2:0] push_count(input logic [5:0] act);
        logic [2:0] n;
        case (act)
            ACT_DROP, ACT_2DROP, ACT_TOR:          n = 3'd0;
            ACT_DUP, ACT_SWAP:                     n = 3'd2;
            ACT_OVER, ACT_ROT, ACT_TUCK:           n = 3'd3;
            ACT_2DUP, ACT_2SWAP:                   n = 3'd4;
            default:                               n = (act > ACT_ZGT) ? 3'd0 : 3'd1;
        endcase
        return n;
    endfunction

endpackage

/* design/fsa_front.sv */
module fsa_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [5:0]    i_action,
    input  logic [63:0]   i_literal,
    output logic          o_valid,
    output fsa_pkg::t_item o_item,
    input  logic          i_pop
);

    fsa_pkg::t_item r_q [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    fsa_pkg::t_item w_item;
    logic       w_push, w_pop;

    always_comb begin
        w_item.action  = i_action;
        w_item.literal = i_literal;
        w_item.pops    = fsa_pkg::pop_count(i_action);
        w_item.pushes  = fsa_pkg::push_count(i_action);
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_item;
    end

endmodule

/* design/fsa_back.sv */
module fsa_back #(
    parameter int DATA_DEPTH   = 256,
    parameter int RETURN_DEPTH = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  fsa_pkg::t_item i_q_item,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [84:0]    o_result
);

    localparam int DPW = $clog2(DATA_DEPTH + 1);
    localparam int DAW = $clog2(DATA_DEPTH);
    localparam int RPW = $clog2(RETURN_DEPTH + 1);
    localparam int RAW = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;

    fsa_pkg::t_state r_state, n_state;
    fsa_pkg::t_item  r_cur;
    logic [DPW-1:0]  r_dp;
    logic [RPW-1:0]  r_rp;
    logic [63:0]     r_top, r_dq, r_rq, r_prod, r_acc, r_q, r_dv, r_rem;
    logic [63:0]     r_x   [0:4];
    logic [63:0]     r_res [0:3];
    logic [2:0]      r_k, r_err;
    logic [6:0]      r_cnt;
    logic            r_sa, r_sb, r_ovalid;
    logic [84:0]     r_out;

    logic [63:0] dmem [0:DATA_DEPTH-1];
    logic [63:0] rmem [0:RETURN_DEPTH-1];

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // decode and checks
    logic [DPW-1:0] np_w, pb;
    logic [DPW:0]   grow;
    logic [2:0]     rc;
    logic           under, ret_ovr, ret_und, ovf, div0, is_div, out_free;
    logic [63:0]    a, b, n_res [0:3];
    logic [64:0]    rem_sh, rem_nx;
    logic           ge;
    logic [63:0]    q_nx;
    logic [31:0]    mul_a, mul_b;
    logic           d_re, d_we, r_re, r_we;
    logic [DAW-1:0] d_ra, d_wa;
    logic [RAW-1:0] r_ra, r_wa;

    assign np_w    = DPW'(r_cur.pops);
    assign under   = r_dp < np_w;
    assign rc      = (r_dp > np_w) ? (r_cur.pops + 3'd1) : r_cur.pops;
    assign pb      = r_dp - np_w;
    assign grow    = {1'b0, pb} + (DPW+1)'(r_cur.pushes);
    assign ovf     = grow > (DPW+1)'(DATA_DEPTH);
    assign ret_ovr = (r_cur.action == fsa_pkg::ACT_TOR) && (r_rp >= RPW'(RETURN_DEPTH));
    assign ret_und = ((r_cur.action == fsa_pkg::ACT_RFROM) ||
                      (r_cur.action == fsa_pkg::ACT_RFETCH)) && (r_rp == '0);
    assign is_div  = (r_cur.action == fsa_pkg::ACT_DIV) || (r_cur.action == fsa_pkg::ACT_MOD);
    assign a       = r_x[1];
    assign b       = r_x[0];
    assign div0    = is_div && (b == 64'd0);
    assign out_free = !r_ovalid || i_ready;

    assign rem_sh = {r_rem, r_q[63]};
    assign ge     = rem_sh >= {1'b0, r_dv};
    assign rem_nx = ge ? (rem_sh - {1'b0, r_dv}) : rem_sh;
    assign q_nx   = {r_q[62:0], ge};

    always_comb begin
        unique case (r_k[1:0])
            2'd0:    begin mul_a = a[31:0];  mul_b = b[31:0];  end
            2'd1:    begin mul_a = a[31:0];  mul_b = b[63:32]; end
            default: begin mul_a = a[63:32]; mul_b = b[31:0];  end
        endcase
    end

    always_comb begin
        for (int i = 0; i < 4; i++) n_res[i] = 64'd0;
        case (r_cur.action)
            fsa_pkg::ACT_LIT:    n_res[0] = r_cur.literal;
            fsa_pkg::ACT_DUP:    begin n_res[0] = b; n_res[1] = b; end
            fsa_pkg::ACT_SWAP:   begin n_res[0] = b; n_res[1] = a; end
            fsa_pkg::ACT_OVER:   begin n_res[0] = a; n_res[1] = b; n_res[2] = a; end
            fsa_pkg::ACT_ROT:    begin n_res[0] = r_x[1]; n_res[1] = r_x[0]; n_res[2] = r_x[2]; end
            fsa_pkg::ACT_NIP:    n_res[0] = b;
            fsa_pkg::ACT_TUCK:   begin n_res[0] = b; n_res[1] = a; n_res[2] = b; end
            fsa_pkg::ACT_2DUP:   begin
                n_res[0] = a; n_res[1] = b; n_res[2] = a; n_res[3] = b;
            end
            fsa_pkg::ACT_2SWAP:  begin
                n_res[0] = r_x[1]; n_res[1] = r_x[0]; n_res[2] = r_x[3]; n_res[3] = r_x[2];
            end
            fsa_pkg::ACT_RFROM,
            fsa_pkg::ACT_RFETCH: n_res[0] = r_rq;
            fsa_pkg::ACT_ADD:    n_res[0] = a + b;
            fsa_pkg::ACT_SUB:    n_res[0] = a - b;
            fsa_pkg::ACT_ABS:    n_res[0] = mag(b);
            fsa_pkg::ACT_NEGATE: n_res[0] = 64'd0 - b;
            fsa_pkg::ACT_INC:    n_res[0] = b + 64'd1;
            fsa_pkg::ACT_DEC:    n_res[0] = b - 64'd1;
            fsa_pkg::ACT_AND:    n_res[0] = a & b;
            fsa_pkg::ACT_OR:     n_res[0] = a | b;
            fsa_pkg::ACT_XOR:    n_res[0] = a ^ b;
            fsa_pkg::ACT_INVERT: n_res[0] = ~b;
            fsa_pkg::ACT_LSHIFT: n_res[0] = (b[63:6] != '0) ? 64'd0 : (a << b[5:0]);
            fsa_pkg::ACT_RSHIFT: n_res[0] = (b[63:6] != '0) ? 64'd0 : (a >> b[5:0]);
            fsa_pkg::ACT_LT:  n_res[0] = ($signed(a) <  $signed(b)) ? fsa_pkg::ALL_ONES : 64'd0;
            fsa_pkg::ACT_GT:  n_res[0] = ($signed(a) >  $signed(b)) ? fsa_pkg::ALL_ONES : 64'd0;
            fsa_pkg::ACT_EQ:  n_res[0] = (a == b) ? fsa_pkg::ALL_ONES : 64'd0;
            fsa_pkg::ACT_NE:  n_res[0] = (a != b) ? fsa_pkg::ALL_ONES : 64'd0;
            fsa_pkg::ACT_LE:  n_res[0] = ($signed(a) <= $signed(b)) ? fsa_pkg::ALL_ONES : 64'd0;
            fsa_pkg::ACT_GE:  n_res[0] = ($signed(a) >= $signed(b)) ? fsa_pkg::ALL_ONES : 64'd0;
            fsa_pkg::ACT_ZEQ: n_res[0] = (b == 64'd0) ? fsa_pkg::ALL_ONES : 64'd0;
            fsa_pkg::ACT_ZLT: n_res[0] = b[63] ? fsa_pkg::ALL_ONES : 64'd0;
            fsa_pkg::ACT_ZGT: n_res[0] = (!b[63] && b != 64'd0) ? fsa_pkg::ALL_ONES : 64'd0;
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fsa_pkg::ST_IDLE:  if (i_q_valid) n_state = fsa_pkg::ST_CHECK;
            fsa_pkg::ST_CHECK: n_state = (under || ret_ovr || ret_und) ? fsa_pkg::ST_DONE
                                                                      : fsa_pkg::ST_READ;
            fsa_pkg::ST_READ:  if (r_k == rc) n_state = fsa_pkg::ST_EVAL;
            fsa_pkg::ST_EVAL: begin
                if (div0 || ovf)                             n_state = fsa_pkg::ST_DONE;
                else if (r_cur.action == fsa_pkg::ACT_MUL)   n_state = fsa_pkg::ST_MUL;
                else if (is_div)                             n_state = fsa_pkg::ST_DIV;
                else                                         n_state = fsa_pkg::ST_WRITE;
            end
            fsa_pkg::ST_MUL:   if (r_k == 3'd3) n_state = fsa_pkg::ST_WRITE;
            fsa_pkg::ST_DIV:   if (r_cnt == 7'd63) n_state = fsa_pkg::ST_WRITE;
            fsa_pkg::ST_WRITE: if (r_k == r_cur.pushes) n_state = fsa_pkg::ST_DONE;
            fsa_pkg::ST_DONE:  if (out_free) n_state = fsa_pkg::ST_IDLE;
            default:           n_state = fsa_pkg::ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        o_q_pop = (r_state == fsa_pkg::ST_IDLE) && i_q_valid;
        d_re    = (r_state == fsa_pkg::ST_READ) && (r_k < rc);
        d_ra    = DAW'(r_dp - DPW'(1) - DPW'(r_k));
        d_we    = (r_state == fsa_pkg::ST_WRITE) && (r_k < r_cur.pushes);
        d_wa    = DAW'(pb + DPW'(r_k));
        r_re    = (r_state == fsa_pkg::ST_CHECK);
        r_ra    = RAW'(r_rp - RPW'(1));
        r_we    = (r_state == fsa_pkg::ST_EVAL) && !div0 && !ovf &&
                  (r_cur.action == fsa_pkg::ACT_TOR);
        r_wa    = RAW'(r_rp);
        o_valid  = r_ovalid;
        o_result = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (d_we) dmem[d_wa] <= r_res[r_k[1:0]];
        if (d_re) r_dq <= dmem[d_ra];
    end

    always_ff @(posedge i_clk) begin
        if (r_we) rmem[r_wa] <= b;
        if (r_re) r_rq <= rmem[r_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fsa_pkg::ST_IDLE;
            r_dp     <= '0;
            r_rp     <= '0;
            r_top    <= 64'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == fsa_pkg::ST_DONE) && out_free) r_ovalid <= 1'b1;
            else if (i_ready)                             r_ovalid <= 1'b0;
            unique case (r_state)
                fsa_pkg::ST_IDLE: begin
                    r_cur <= i_q_item;
                    r_err <= fsa_pkg::ERR_OK;
                    r_k   <= 3'd0;
                end
                fsa_pkg::ST_CHECK: begin
                    if (under)        r_err <= fsa_pkg::ERR_D_UNDER;
                    else if (ret_ovr) r_err <= fsa_pkg::ERR_R_OVER;
                    else if (ret_und) r_err <= fsa_pkg::ERR_R_UNDER;
                end
                fsa_pkg::ST_READ: begin
                    if (r_k != 3'd0) r_x[r_k - 3'd1] <= r_dq;
                    r_k <= (r_k == rc) ? 3'd0 : r_k + 3'd1;
                end
                fsa_pkg::ST_EVAL: begin
                    r_k   <= 3'd0;
                    r_cnt <= 7'd0;
                    r_q   <= mag(a);
                    r_dv  <= mag(b);
                    r_rem <= 64'd0;
                    r_sa  <= a[63];
                    r_sb  <= b[63];
                    for (int i = 0; i < 4; i++) r_res[i] <= n_res[i];
                    if (div0)     r_err <= fsa_pkg::ERR_DIV0;
                    else if (ovf) r_err <= fsa_pkg::ERR_D_OVER;
                    else if (r_cur.action == fsa_pkg::ACT_TOR)   r_rp <= r_rp + RPW'(1);
                    else if (r_cur.action == fsa_pkg::ACT_RFROM) r_rp <= r_rp - RPW'(1);
                end
                fsa_pkg::ST_MUL: begin
                    // low 64 bits only: al*bl + (al*bh + ah*bl) << 32
                    r_prod <= 64'(mul_a) * 64'(mul_b);
                    if (r_k == 3'd1) r_acc <= r_prod;
                    if (r_k == 3'd2) r_acc <= r_acc + {r_prod[31:0], 32'd0};
                    if (r_k == 3'd3) r_res[0] <= r_acc + {r_prod[31:0], 32'd0};
                    r_k <= (r_k == 3'd3) ? 3'd0 : r_k + 3'd1;
                end
                fsa_pkg::ST_DIV: begin
                    r_q   <= q_nx;
                    r_rem <= rem_nx[63:0];
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd63) begin
                        if (r_cur.action == fsa_pkg::ACT_DIV)
                            r_res[0] <= (r_sa ^ r_sb) ? (64'd0 - q_nx) : q_nx;
                        else
                            r_res[0] <= r_sa ? (64'd0 - rem_nx[63:0]) : rem_nx[63:0];
                    end
                end
                fsa_pkg::ST_WRITE: begin
                    r_k <= r_k + 3'd1;
                    if (r_k == r_cur.pushes) begin
                        r_dp <= DPW'(grow);
                        if (r_cur.pushes != 3'd0)
                            r_top <= r_res[2'(r_cur.pushes - 3'd1)];
                        else if (pb != '0)
                            r_top <= r_x[r_cur.pops];
                        else
                            r_top <= 64'd0;
                    end
                end
                fsa_pkg::ST_DONE: begin
                    if (out_free) r_out <= {r_err, 9'(r_rp), 9'(r_dp), r_top};
                end
                default: ;
            endcase
        end
    end

endmodule

/* design/forth_stack_alu.sv */
// Forth primitive executor with a data stack and a return stack of 64-bit
// entries, each held in a single-port-write memory. One result per input:
// new top, both depths, error code. Items run one at a time through a
// sequencer that reads operands one entry per cycle and writes results one
// entry per cycle; it reads the popped operands plus one entry below them
// when there is one. An item rejected on a data underflow or return-stack
// check skips the reads and writes. * forms the low 64 bits from 32x32
// partial products and / and MOD use a bit-serial divider. A two-entry queue
// in front takes new items while the sequencer works, and an output register
// holds a finished result.
module forth_stack_alu #(
    parameter int DATA_DEPTH   = 256,
    parameter int RETURN_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // action[5:0], literal_value[69:6], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata    // top_value[63:0], data_depth[72:64],
                                        // return_depth[81:73], error_code[84:82]
);

    logic           q_valid, q_pop;
    fsa_pkg::t_item q_item;
    logic [84:0]    result;

    fsa_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_action  (s_axis_tdata[5:0]),
        .i_literal (s_axis_tdata[69:6]),
        .o_valid   (q_valid),
        .o_item    (q_item),
        .i_pop     (q_pop)
    );

    fsa_back #(
        .DATA_DEPTH   (DATA_DEPTH),
        .RETURN_DEPTH (RETURN_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (result)
    );

    assign m_axis_tdata = {3'd0, result};

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[84:82] <= fsa_pkg::ERR_DIV0)
        else $error("error code out of range");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[72:64] == 9'd0) |-> m_axis_tdata[63:0] == 64'd0)
        else $error("nonzero top on empty data stack");

    a_rdepth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> 32'(m_axis_tdata[81:73]) <= RETURN_DEPTH)
        else $error("return depth beyond capacity");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
    import fsa_pkg::*;

    localparam int DDEPTH = 256;
    localparam int RDEPTH = 256;

    typedef struct packed {
        logic [63:0] top;
        logic [8:0]  ddepth;
        logic [8:0]  rdepth;
        logic [2:0]  err;
    } t_outcome;

    typedef struct {
        logic [5:0]  act;
        logic [63:0] lit;
        logic        has_exp;
        t_outcome    exp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // action[5:0], literal_value[69:6], zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;   // top, data_depth, return_depth, error_code

    forth_stack_alu uut (.*);

    // predictor state
    logic [63:0] dstk [DDEPTH];
    logic [63:0] rstk [RDEPTH];
    int          dptr, rptr;

    t_outcome    pending_q [$];
    int          errors;
    bit          hold_off;
    bit          stim_done;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [63:0] truth(bit c);
        return c ? ALL_ONES : 64'd0;
    endfunction

    function automatic logic [63:0] mag(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic t_outcome forth_execute(logic [5:0] act, logic [63:0] lit);
        t_outcome    o;
        logic [63:0] x [4];
        logic [63:0] r [4];
        logic [63:0] a, b, q;
        int          np, nr, e;
        np = pop_count(act);
        nr = push_count(act);
        e = ERR_OK;
        for (int i = 0; i < 4; i++) begin
            x[i] = '0;
            r[i] = '0;
        end
        if (dptr < np) begin
            e = ERR_D_UNDER;
        end else if (act == ACT_TOR && rptr >= RDEPTH) begin
            e = ERR_R_OVER;
        end else if ((act == ACT_RFROM || act == ACT_RFETCH) && rptr == 0) begin
            e = ERR_R_UNDER;
        end
        if (e == ERR_OK) begin
            for (int i = 0; i < np; i++) x[i] = dstk[dptr - 1 - i];
            if ((act == ACT_DIV || act == ACT_MOD) && x[0] == 0) e = ERR_DIV0;
            else if (dptr - np + nr > DDEPTH) e = ERR_D_OVER;
        end
        if (e == ERR_OK) begin
            a = x[1];
            b = x[0];
            case (act)
                ACT_LIT:    r[0] = lit;
                ACT_DUP:    begin r[0] = b; r[1] = b; end
                ACT_SWAP:   begin r[0] = b; r[1] = a; end
                ACT_OVER:   begin r[0] = a; r[1] = b; r[2] = a; end
                ACT_ROT:    begin r[0] = x[1]; r[1] = x[0]; r[2] = x[2]; end
                ACT_NIP:    r[0] = b;
                ACT_TUCK:   begin r[0] = b; r[1] = a; r[2] = b; end
                ACT_2DUP:   begin r[0] = a; r[1] = b; r[2] = a; r[3] = b; end
                ACT_2SWAP:  begin r[0] = x[1]; r[1] = x[0]; r[2] = x[3]; r[3] = x[2]; end
                ACT_TOR:    begin rstk[rptr] = b; rptr++; end
                ACT_RFROM:  begin rptr--; r[0] = rstk[rptr]; end
                ACT_RFETCH: r[0] = rstk[rptr - 1];
                ACT_ADD:    r[0] = a + b;
                ACT_SUB:    r[0] = a - b;
                ACT_MUL:    r[0] = a * b;
                ACT_DIV: begin
                    q = mag(a) / mag(b);
                    r[0] = (a[63] ^ b[63]) ? -q : q;
                end
                ACT_MOD: begin
                    q = mag(a) % mag(b);
                    r[0] = a[63] ? -q : q;
                end
                ACT_ABS:    r[0] = mag(b);
                ACT_NEGATE: r[0] = -b;
                ACT_INC:    r[0] = b + 1;
                ACT_DEC:    r[0] = b - 1;
                ACT_AND:    r[0] = a & b;
                ACT_OR:     r[0] = a | b;
                ACT_XOR:    r[0] = a ^ b;
                ACT_INVERT: r[0] = ~b;
                ACT_LSHIFT: r[0] = (b > 63) ? 64'd0 : a << b[5:0];
                ACT_RSHIFT: r[0] = (b > 63) ? 64'd0 : a >> b[5:0];
                ACT_LT:     r[0] = truth($signed(a) < $signed(b));
                ACT_GT:     r[0] = truth($signed(a) > $signed(b));
                ACT_EQ:     r[0] = truth(a == b);
                ACT_NE:     r[0] = truth(a != b);
                ACT_LE:     r[0] = truth($signed(a) <= $signed(b));
                ACT_GE:     r[0] = truth($signed(a) >= $signed(b));
                ACT_ZEQ:    r[0] = truth(b == 0);
                ACT_ZLT:    r[0] = truth(b[63]);
                ACT_ZGT:    r[0] = truth(b != 0 && !b[63]);
                default:    ;
            endcase
            dptr -= np;
            for (int i = 0; i < nr; i++) begin
                dstk[dptr] = r[i];
                dptr++;
            end
        end
        o.top = dptr ? dstk[dptr - 1] : 64'd0;
        o.ddepth = dptr[8:0];
        o.rdepth = rptr[8:0];
        o.err = e[2:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
        errors++;
    endtask

    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 2) != 0) return;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (n) @(negedge i_clk);
    endtask

    // sends one transaction; the predictor runs at acceptance
    task automatic send_item(logic [5:0] act, logic [63:0] lit, bit has_exp,
                             t_outcome want);
        t_outcome pred;
        s_axis_tdata  = {2'b0, lit, act};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = forth_execute(act, lit);
        if (has_exp && pred !== want)
            report_mismatch("table row", pred, want);
        pending_q.push_back(pred);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return ALL_ONES;
            3: return 64'd0;
            4: return 64'($urandom_range(0, 70));
            5: return -64'($urandom_range(1, 70));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [5:0] rand_action();
        int k;
        k = $urandom_range(0, 99);
        if (k < 28) return ACT_LIT;
        if (k < 31) return 6'($urandom_range(38, 63));
        return 6'($urandom_range(1, 37));
    endfunction

    task automatic wait_drained();
        while (pending_q.size() != 0) @(negedge i_clk);
    endtask

    // receiver: random stalls plus one long hold-off
    initial begin
        int n;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (60) @(negedge i_clk);
                hold_off = 1'b0;
            end
            if (stim_done || $urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
                repeat (n - 1) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.top    = m_axis_tdata[63:0];
            got.ddepth = m_axis_tdata[72:64];
            got.rdepth = m_axis_tdata[81:73];
            got.err    = m_axis_tdata[84:82];
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected transaction", got.top, 64'd0);
            end else begin
                want = pending_q.pop_front();
                if (got.top !== want.top) report_mismatch("top_value", got.top, want.top);
                if (got.ddepth !== want.ddepth)
                    report_mismatch("data_depth", 64'(got.ddepth), 64'(want.ddepth));
                if (got.rdepth !== want.rdepth)
                    report_mismatch("return_depth", 64'(got.rdepth), 64'(want.rdepth));
                if (got.err !== want.err)
                    report_mismatch("error_code", 64'(got.err), 64'(want.err));
            end
        end
    end

    t_row plan [$];

    function automatic t_outcome oc(logic [63:0] t, int d, int r, logic [2:0] e);
        t_outcome o;
        o.top = t;
        o.ddepth = 9'(d);
        o.rdepth = 9'(r);
        o.err = e;
        return o;
    endfunction

    function automatic void add_row(logic [5:0] act, logic [63:0] lit, bit he = 0,
                                    t_outcome o = '0);
        t_row row;
        row.act = act;
        row.lit = lit;
        row.has_exp = he;
        row.exp = o;
        plan.push_back(row);
    endfunction

    initial begin
        int sent, depth;
        bit held, drained, dfilled, rfilled;
        errors = 0;
        hold_off = 0;
        stim_done = 0;
        held = 0;
        drained = 0;
        dfilled = 0;
        rfilled = 0;
        dptr = 0;
        rptr = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-stack errors, extremes, wrap cases, div by zero
        add_row(ACT_DROP, 0, 1, oc(0, 0, 0, ERR_D_UNDER));
        add_row(ACT_RFROM, 0, 1, oc(0, 0, 0, ERR_R_UNDER));
        add_row(ACT_RFETCH, 0, 1, oc(0, 0, 0, ERR_R_UNDER));
        add_row(6'd63, 0, 1, oc(0, 0, 0, ERR_OK));
        add_row(ACT_LIT, 64'h8000_0000_0000_0000, 1, oc(64'h8000_0000_0000_0000, 1, 0, ERR_OK));
        add_row(ACT_ABS, 0, 1, oc(64'h8000_0000_0000_0000, 1, 0, ERR_OK));
        add_row(ACT_NEGATE, 0, 1, oc(64'h8000_0000_0000_0000, 1, 0, ERR_OK));
        add_row(ACT_LIT, ALL_ONES, 1, oc(ALL_ONES, 2, 0, ERR_OK));
        add_row(ACT_2DUP, 0);
        add_row(ACT_DIV, 0, 1, oc(64'h8000_0000_0000_0000, 3, 0, ERR_OK));
        add_row(ACT_SWAP, 0);
        add_row(ACT_MOD, 0, 1, oc(0, 2, 0, ERR_OK));
        add_row(ACT_DIV, 0, 1, oc(0, 2, 0, ERR_DIV0));
        add_row(ACT_LIT, 64'h7FFF_FFFF_FFFF_FFFF);
        add_row(ACT_INC, 0);
        add_row(ACT_LIT, 64);
        add_row(ACT_LSHIFT, 0, 1, oc(0, 3, 0, ERR_OK));
        add_row(ACT_LIT, ALL_ONES);
        add_row(ACT_RSHIFT, 0);
        add_row(ACT_TOR, 0);
        add_row(ACT_RFETCH, 0);
        add_row(ACT_RFROM, 0);
        add_row(ACT_2SWAP, 0);
        add_row(ACT_ROT, 0);
        add_row(ACT_ZLT, 0);
        foreach (plan[i]) begin
            send_item(plan[i].act, plan[i].lit, plan[i].has_exp, plan[i].exp);
            idle_gap();
        end
        sent = 0;
        while (sent < 1750) begin
            if (!held && sent >= 300) begin
                // long receiver hold-off while we keep offering
                held = 1'b1;
                hold_off = 1'b1;
                repeat (40) begin
                    send_item(ACT_LIT, rand64(), 0, '0);
                    sent++;
                end
            end else if (!dfilled && sent >= 450) begin
                // fill data stack to overflow, then drain
                dfilled = 1'b1;
                depth = DDEPTH - dptr + 2;
                repeat (depth) begin
                    send_item(ACT_LIT, rand64(), 0, '0);
                    sent++;
                end
                send_item(ACT_2DUP, 0, 0, '0);
                repeat (DDEPTH / 2) begin
                    send_item(ACT_2DROP, 0, 0, '0);
                    sent++;
                end
            end else if (!drained && sent >= 600) begin
                drained = 1'b1;
                wait_drained();
            end else if (!rfilled && sent >= 900) begin
                // fill return stack to overflow, then drain half of it
                rfilled = 1'b1;
                repeat (RDEPTH - rptr + 1) begin
                    send_item(ACT_LIT, rand64(), 0, '0);
                    send_item(ACT_TOR, 0, 0, '0);
                    sent += 2;
                end
                repeat (RDEPTH / 2) begin
                    send_item(ACT_RFROM, 0, 0, '0);
                    send_item(ACT_DROP, 0, 0, '0);
                    sent += 2;
                end
            end else begin
                if (dptr < 3) begin
                    send_item(ACT_LIT, rand64(), 0, '0);
                    sent++;
                end
                send_item(rand_action(), rand64(), 0, '0);
                sent++;
                idle_gap();
            end
        end
        stim_done = 1'b1;
        wait_drained();
        repeat (200) @(negedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

/* filelist.f */
design/fsa_pkg.sv
design/fsa_front.sv
design/fsa_back.sv
design/forth_stack_alu.sv
verif/tb.sv
